FILE: hdl/pmc_pkg.sv
`default_nettype none

package pmc_pkg;

    localparam int ROW_W  = 64;   // predecessor row width
    localparam int NODE_W = 6;    // node number width
    localparam int CNT_W  = 7;    // node count width
    localparam int ADDR_W = 3;    // register port byte address width
    localparam int DATA_W = 32;   // register port data width

    // register word index (paddr[2])
    localparam logic [0:0] REG_NODE_COUNT = 1'b0;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;

    // one row beat: on the load side and on the result side
    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [ROW_W-1:0]  bits;
        logic              last;
    } row_beat_t;

endpackage

`default_nettype wire

FILE: hdl/pmc_core.sv
`default_nettype none

module pmc_core #(
    parameter int MAX_NODES = 64
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [pmc_pkg::CNT_W-1:0] node_count,
    input  wire logic                      load_valid,
    output logic                           load_ready,
    input  wire pmc_pkg::row_beat_t        load_beat,
    output logic                           emit_valid,
    input  wire logic                      emit_take,
    output pmc_pkg::row_beat_t             emit_beat
);

    localparam int AW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int ROW_W = pmc_pkg::ROW_W;
    localparam int CNT_W = pmc_pkg::CNT_W;

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_B_RD   = 14'b00000000000010,
        ST_B_EX   = 14'b00000000000100,
        ST_N_RD   = 14'b00000000001000,
        ST_N_SNAP = 14'b00000000010000,
        ST_S_RD   = 14'b00000000100000,
        ST_S_EX   = 14'b00000001000000,
        ST_O_RD   = 14'b00000010000000,
        ST_O_EX   = 14'b00000100000000,
        ST_I_RD   = 14'b00001000000000,
        ST_I_EX   = 14'b00010000000000,
        ST_N_WB   = 14'b00100000000000,
        ST_E_RD   = 14'b01000000000000,
        ST_E_WAIT = 14'b10000000000000
    } state_t;

    typedef enum logic [1:0] {
        RULE_1 = 2'd0,
        RULE_2 = 2'd1,
        RULE_3 = 2'd2
    } rule_t;

    // predecessor rows and their transpose
    logic [ROW_W-1:0] pred_mem [MAX_NODES];
    logic [ROW_W-1:0] succ_mem [MAX_NODES];
    logic [ROW_W-1:0] pred_rd_reg;
    logic [ROW_W-1:0] succ_rd_reg;

    state_t           state_reg, state_next;
    rule_t            rule_reg, rule_next;
    logic [AW-1:0]    a_reg, a_next;
    logic [AW-1:0]    b_reg, b_next;
    logic [AW-1:0]    y_reg, y_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [AW-1:0]    nl_reg, nl_next;
    logic             changed_reg, changed_next;
    logic [ROW_W-1:0] mask_reg, mask_next;
    logic [ROW_W-1:0] acc_reg, acc_next;
    logic [ROW_W-1:0] par_reg, par_next;
    logic [ROW_W-1:0] und_reg, und_next;
    logic [ROW_W-1:0] praw_reg, praw_next;
    logic [ROW_W-1:0] sraw_reg, sraw_next;
    logic [ROW_W-1:0] nb_reg, nb_next;
    logic [ROW_W-1:0] clr_reg, clr_next;

    logic             pred_we, succ_we;
    logic [AW-1:0]    pred_wa, succ_wa, rd_addr;
    logic [ROW_W-1:0] pred_wd, succ_wd;

    logic [CNT_W-1:0] n_eff;
    logic [AW-1:0]    nl_calc;
    logic [ROW_W-1:0] mask_calc;
    logic             store_ok;
    logic [ROW_W-1:0] r_rd, s_rd, adj_rd, bit_a, bit_b, bit_i, acc_v, nb_v, undd;

    always_comb
    begin
        if (node_count == '0)
            n_eff = CNT_W'(1);
        else if (node_count > CNT_W'(MAX_NODES))
            n_eff = CNT_W'(MAX_NODES);
        else
            n_eff = node_count;
        nl_calc = AW'(n_eff - CNT_W'(1));
        for (int i = 0; i < ROW_W; i++)
            mask_calc[i] = (CNT_W'(i) < n_eff);
    end

    assign store_ok = ({1'b0, load_beat.node} < CNT_W'(MAX_NODES));
    assign r_rd     = pred_rd_reg & mask_reg;
    assign s_rd     = succ_rd_reg & mask_reg;
    assign adj_rd   = r_rd | s_rd;
    assign undd     = r_rd & s_rd;
    assign bit_a    = ROW_W'(1) << a_reg;
    assign bit_b    = ROW_W'(1) << b_reg;
    assign bit_i    = ROW_W'(1) << idx_reg;
    assign acc_v    = pred_rd_reg[y_reg] ? (acc_reg | bit_i) : acc_reg;
    assign nb_v     = par_reg & ~adj_rd & ~bit_b;

    assign rd_addr = (state_reg == ST_N_RD) ? a_reg :
                     ((state_reg == ST_O_RD) ? b_reg : idx_reg);

    always_comb
    begin
        state_next   = state_reg;
        rule_next    = rule_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        y_next       = y_reg;
        idx_next     = idx_reg;
        nl_next      = nl_reg;
        changed_next = changed_reg;
        mask_next    = mask_reg;
        acc_next     = acc_reg;
        par_next     = par_reg;
        und_next     = und_reg;
        praw_next    = praw_reg;
        sraw_next    = sraw_reg;
        nb_next      = nb_reg;
        clr_next     = clr_reg;
        pred_we      = 1'b0;
        pred_wa      = idx_reg;
        pred_wd      = pred_rd_reg & ~bit_a;
        succ_we      = 1'b0;
        succ_wa      = idx_reg;
        succ_wd      = succ_rd_reg & ~bit_a;
        load_ready   = 1'b0;
        emit_valid   = 1'b0;
        emit_beat.node = pmc_pkg::NODE_W'(idx_reg);
        emit_beat.bits = pred_rd_reg & mask_reg & ~bit_i;
        emit_beat.last = (idx_reg == nl_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                load_ready = 1'b1;
                if (load_valid)
                begin
                    pred_we = store_ok;
                    pred_wa = load_beat.node[AW-1:0];
                    pred_wd = load_beat.bits & ~(ROW_W'(1) << load_beat.node);
                    if (load_beat.last)
                    begin
                        nl_next    = nl_calc;
                        mask_next  = mask_calc;
                        idx_next   = '0;
                        y_next     = '0;
                        acc_next   = '0;
                        state_next = ST_B_RD;
                    end
                end
            end
            ST_B_RD:
                state_next = ST_B_EX;
            ST_B_EX:
            begin
                // gather column y, one row a step
                if (idx_reg == nl_reg)
                begin
                    succ_we  = 1'b1;
                    succ_wa  = y_reg;
                    succ_wd  = acc_v;
                    acc_next = '0;
                    idx_next = '0;
                    if (y_reg == nl_reg)
                    begin
                        rule_next    = RULE_1;
                        a_next       = '0;
                        changed_next = 1'b0;
                        state_next   = ST_N_RD;
                    end
                    else
                    begin
                        y_next     = y_reg + AW'(1);
                        state_next = ST_B_RD;
                    end
                end
                else
                begin
                    acc_next   = acc_v;
                    idx_next   = idx_reg + AW'(1);
                    state_next = ST_B_RD;
                end
            end
            ST_N_RD:
                state_next = ST_N_SNAP;
            ST_N_SNAP:
            begin
                praw_next  = pred_rd_reg;
                sraw_next  = succ_rd_reg;
                par_next   = r_rd & ~s_rd & ~bit_a;
                und_next   = r_rd & s_rd & ~bit_a;
                clr_next   = '0;
                idx_next   = '0;
                b_next     = '0;
                state_next = (rule_reg == RULE_3) ? ST_O_RD : ST_S_RD;
            end
            ST_S_RD:
                state_next = ST_S_EX;
            ST_S_EX:
            begin
                case (rule_reg)
                    RULE_1:
                    begin
                        if (und_reg[idx_reg] && ((par_reg & ~adj_rd) != '0))
                        begin
                            succ_we      = 1'b1;
                            clr_next     = clr_reg | bit_i;
                            changed_next = 1'b1;
                        end
                    end
                    RULE_2:
                    begin
                        if (und_reg[idx_reg] && ((par_reg & s_rd & ~r_rd) != '0)
                            && pred_rd_reg[a_reg])
                        begin
                            pred_we      = 1'b1;
                            clr_next     = clr_reg | bit_i;
                            changed_next = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (idx_reg == nl_reg)
                    state_next = ST_N_WB;
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = ST_S_RD;
                end
            end
            ST_O_RD:
                state_next = ST_O_EX;
            ST_O_EX:
            begin
                if (par_reg[b_reg] && (nb_v != '0))
                begin
                    nb_next    = nb_v;
                    idx_next   = '0;
                    state_next = ST_I_RD;
                end
                else if (b_reg == nl_reg)
                    state_next = ST_N_WB;
                else
                begin
                    b_next     = b_reg + AW'(1);
                    state_next = ST_O_RD;
                end
            end
            ST_I_RD:
                state_next = ST_I_EX;
            ST_I_EX:
            begin
                if (und_reg[idx_reg] && undd[b_reg] && ((nb_reg & undd) != '0)
                    && pred_rd_reg[a_reg])
                begin
                    pred_we      = 1'b1;
                    clr_next     = clr_reg | bit_i;
                    changed_next = 1'b1;
                end
                if (idx_reg != nl_reg)
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = ST_I_RD;
                end
                else if (b_reg == nl_reg)
                    state_next = ST_N_WB;
                else
                begin
                    b_next     = b_reg + AW'(1);
                    state_next = ST_O_RD;
                end
            end
            ST_N_WB:
            begin
                if (rule_reg == RULE_1)
                begin
                    pred_we = 1'b1;
                    pred_wa = a_reg;
                    pred_wd = praw_reg & ~clr_reg;
                end
                else
                begin
                    succ_we = 1'b1;
                    succ_wa = a_reg;
                    succ_wd = sraw_reg & ~clr_reg;
                end
                if (a_reg != nl_reg)
                begin
                    a_next     = a_reg + AW'(1);
                    state_next = ST_N_RD;
                end
                else if (rule_reg != RULE_3)
                begin
                    rule_next  = (rule_reg == RULE_1) ? RULE_2 : RULE_3;
                    a_next     = '0;
                    state_next = ST_N_RD;
                end
                else if (changed_reg)
                begin
                    rule_next    = RULE_1;
                    a_next       = '0;
                    changed_next = 1'b0;
                    state_next   = ST_N_RD;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_E_RD;
                end
            end
            ST_E_RD:
                state_next = ST_E_WAIT;
            ST_E_WAIT:
            begin
                emit_valid = 1'b1;
                if (emit_take)
                begin
                    if (idx_reg == nl_reg)
                        state_next = ST_IDLE;
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_E_RD;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pred_we)
            pred_mem[pred_wa] <= pred_wd;
        if (succ_we)
            succ_mem[succ_wa] <= succ_wd;
        pred_rd_reg <= pred_mem[rd_addr];
        succ_rd_reg <= succ_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rule_reg    <= RULE_1;
            a_reg       <= '0;
            b_reg       <= '0;
            y_reg       <= '0;
            idx_reg     <= '0;
            nl_reg      <= '0;
            changed_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rule_reg    <= rule_next;
            a_reg       <= a_next;
            b_reg       <= b_next;
            y_reg       <= y_next;
            idx_reg     <= idx_next;
            nl_reg      <= nl_next;
            changed_reg <= changed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
        acc_reg  <= acc_next;
        par_reg  <= par_next;
        und_reg  <= und_next;
        praw_reg <= praw_next;
        sraw_reg <= sraw_next;
        nb_reg   <= nb_next;
        clr_reg  <= clr_next;
    end

endmodule

`default_nettype wire

FILE: hdl/pdag_meek_rules_closure.sv
`default_nettype none

// Meek rules 1 to 3 closure over a partially directed graph. Load the graph
// one predecessor row per input beat (bit u of row v: u->v or u-v); rows load
// at one beat per cycle while the core is idle. The beat with last_row set
// starts the closure: first a transpose pass builds the successor store for
// the n nodes in use, then passes of rules 1, 2 and 3 over nodes 0..n-1 repeat
// until a pass orients nothing. For rule 3 each node also rescans all n rows
// for every parent that has a non-adjacent fellow parent; the row stores share
// a single read address and are read one row of each store at a time. Then n
// result beats follow, one at a time, with out_last on node n-1; no input beat
// is taken until the last result beat has left the core. node_count
// (register 0) must be written only while idle; the block itself does not
// enforce this. 0 acts as 1 and values above MAX_NODES as MAX_NODES. Rows
// never loaded read back undefined.

module pdag_meek_rules_closure #(
    parameter int MAX_NODES = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pmc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [pmc_pkg::DATA_W-1:0]  pwdata,
    output logic      [pmc_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [pmc_pkg::NODE_W-1:0]  row_node,
    input  wire logic [pmc_pkg::ROW_W-1:0]   pred_bits,
    input  wire logic                        last_row,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [pmc_pkg::NODE_W-1:0]  out_node,
    output logic      [pmc_pkg::ROW_W-1:0]   out_pred_bits,
    output logic                             out_last
);

    localparam int CNT_W  = pmc_pkg::CNT_W;
    localparam int DATA_W = pmc_pkg::DATA_W;

    logic [CNT_W-1:0]   node_count_reg;
    logic               reg_write;
    logic               reg_hit;

    pmc_pkg::row_beat_t load_beat;
    pmc_pkg::row_beat_t emit_beat;
    logic               emit_valid;
    logic               emit_take;

    logic               out_valid_reg;
    pmc_pkg::row_beat_t out_beat_reg;

    // register port: zero wait states, word index in paddr[2]
    assign pready    = 1'b1;
    assign reg_hit   = (paddr[2] == pmc_pkg::REG_NODE_COUNT);
    assign reg_write = psel && penable && pwrite && reg_hit;
    assign prdata    = reg_hit ? DATA_W'(node_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            node_count_reg <= pmc_pkg::NODE_COUNT_RST;
        else if (reg_write)
            node_count_reg <= pwdata[CNT_W-1:0];
    end

    assign load_beat.node = row_node;
    assign load_beat.bits = pred_bits;
    assign load_beat.last = last_row;

    pmc_core #(
        .MAX_NODES (MAX_NODES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .node_count (node_count_reg),
        .load_valid (in_valid),
        .load_ready (in_ready),
        .load_beat  (load_beat),
        .emit_valid (emit_valid),
        .emit_take  (emit_take),
        .emit_beat  (emit_beat)
    );

    // result register: take a new beat whenever the slot is empty or leaving
    assign emit_take = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_take)
            out_valid_reg <= emit_valid;
    end

    always_ff @(posedge clk)
    begin
        if (emit_take && emit_valid)
            out_beat_reg <= emit_beat;
    end

    assign out_valid     = out_valid_reg;
    assign out_node      = out_beat_reg.node;
    assign out_pred_bits = out_beat_reg.bits;
    assign out_last      = out_beat_reg.last;

endmodule

`default_nettype wire
